>>> rtl/hmcv_pkg.sv
`default_nettype none

package hmcv_pkg;

  localparam int TREE_BITS_DEF    = 10;
  localparam int MAP_BITS_DEF     = 8;
  localparam int COLUMN_DEPTH_DEF = 10;

  localparam int OP_FIFO_DEPTH  = 4;
  localparam int COL_FIFO_DEPTH = 8;
  localparam int COL_CNT_W      = $clog2(COL_FIFO_DEPTH + 1);

  localparam int GRID_W    = 10;
  localparam int IDX_W     = 16;
  localparam int SAMPLE_W  = 17;
  localparam int SIDE_W    = 9;
  localparam int RATIO_W   = 25;
  localparam int FRAC_W    = 24;
  localparam int COORD_W   = 11;
  localparam int ROW_W     = 20;
  localparam int HEIGHT_W  = 10;
  localparam int MORTON_W  = 30;
  localparam int PROD_W    = RATIO_W + GRID_W;
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 40;

  localparam logic [SIDE_W-1:0]  MAP_SIDE_RST   = 9'd256;
  localparam logic [RATIO_W-1:0] STEP_RATIO_RST = 25'd4182004;

  typedef enum logic {
    CFG_MAP_SIDE   = 1'b0,
    CFG_STEP_RATIO = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_GEN   = 1'b1
  } func_e;

  typedef enum logic {
    SMP_IDLE,
    SMP_ROWB
  } smp_state_e;

  typedef struct packed {
    func_e               func;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] value;
    logic [GRID_W-1:0]   gx;
    logic [GRID_W-1:0]   gz;
  } in_t;

  typedef struct packed {
    func_e               func;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] value;
    logic [GRID_W-1:0]   gx;
    logic [GRID_W-1:0]   gz;
    logic [FRAC_W-1:0]   fx;
    logic [FRAC_W-1:0]   fz;
    logic [COORD_W-1:0]  x1;
    logic [COORD_W-1:0]  x2;
    logic [ROW_W-1:0]    r1;
    logic [ROW_W-1:0]    r2;
  } op_t;

  typedef struct packed {
    logic [GRID_W-1:0]   gx;
    logic [GRID_W-1:0]   gz;
    logic [HEIGHT_W-1:0] hlo;
  } col_t;

  function automatic logic [MORTON_W-1:0] interleave3(input logic [GRID_W-1:0] x,
                                                       input logic [GRID_W-1:0] y,
                                                       input logic [GRID_W-1:0] z);
    logic [MORTON_W-1:0] r;
    r = '0;
    for (int i = 0; i < GRID_W; i++) begin
      r[3*i]   = x[i];
      r[3*i+1] = y[i];
      r[3*i+2] = z[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/heightmap_column_voxelizer_unit.sv
// Channel   Direction  tdata (low bit up)                                  Side band
// s_axis    in         sample_index, sample_value, grid_x, grid_z (56 b)   tuser = func
// m_axis    out        morton_code, column_height (40 b)                   tlast = last
// cfg       in         cfg_idx_i 0 = map_side, 1 = step_ratio              no handshake
//
// A write beat is taken every cycle while the sampler is idle and the operation queue
// has room; a generate beat holds both read ports of the height memory for its second
// row read, and the sampler takes no other operation during that read. The output port
// sets the sustained rate: each full column is COLUMN_DEPTH output beats. Reset clears only
// control state, and the height memory holds no data until written.
// Back-pressure on m_axis fills the column queue, then the operation queue, then
// drops s_axis_tready.
`default_nettype none

module heightmap_column_voxelizer_unit #(
  parameter int TREE_BITS    = hmcv_pkg::TREE_BITS_DEF,
  parameter int MAP_BITS     = hmcv_pkg::MAP_BITS_DEF,
  parameter int COLUMN_DEPTH = hmcv_pkg::COLUMN_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_index[15:0], sample_value[32:16], grid_x[42:33], grid_z[52:43]
  input  logic [hmcv_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // func[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // morton_code[29:0], column_height[39:30]
  output logic [hmcv_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [hmcv_pkg::RATIO_W-1:0]       cfg_data_i
);

  localparam int OpW  = $bits(hmcv_pkg::op_t);
  localparam int ColW = $bits(hmcv_pkg::col_t);

  logic [hmcv_pkg::SIDE_W-1:0]  map_side_q;
  logic [hmcv_pkg::RATIO_W-1:0] step_ratio_q;

  hmcv_pkg::in_t  in_beat;
  hmcv_pkg::op_t  front_op, fifo_op;
  hmcv_pkg::col_t smp_col, fifo_col;
  logic [OpW-1:0]  fifo_op_raw;
  logic [ColW-1:0] fifo_col_raw;

  logic front_valid, op_full, op_valid, op_pop;
  logic col_push, col_valid, col_pop;
  logic [hmcv_pkg::COL_CNT_W-1:0] col_count;
  logic [hmcv_pkg::MORTON_W-1:0]  out_code;
  logic [hmcv_pkg::HEIGHT_W-1:0]  out_height;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_side_q   <= hmcv_pkg::MAP_SIDE_RST;
      step_ratio_q <= hmcv_pkg::STEP_RATIO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hmcv_pkg::CFG_MAP_SIDE:   map_side_q   <= cfg_data_i[hmcv_pkg::SIDE_W-1:0];
        hmcv_pkg::CFG_STEP_RATIO: step_ratio_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_beat.func  = hmcv_pkg::func_e'(s_axis_tuser);
  assign in_beat.idx   = s_axis_tdata[15:0];
  assign in_beat.value = s_axis_tdata[32:16];
  assign in_beat.gx    = s_axis_tdata[42:33];
  assign in_beat.gz    = s_axis_tdata[52:43];

  hmcv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_i         (in_beat),
    .map_side_i   (map_side_q),
    .step_ratio_i (step_ratio_q),
    .op_valid_o   (front_valid),
    .op_ready_i   (!op_full),
    .op_o         (front_op)
  );

  hmcv_fifo #(
    .WIDTH (OpW),
    .DEPTH (hmcv_pkg::OP_FIFO_DEPTH)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid && !op_full),
    .data_i  (front_op),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .valid_o (op_valid),
    .data_o  (fifo_op_raw),
    .count_o ()
  );

  assign fifo_op = hmcv_pkg::op_t'(fifo_op_raw);

  hmcv_sampler #(
    .MAP_BITS     (MAP_BITS),
    .TREE_BITS    (TREE_BITS),
    .COLUMN_DEPTH (COLUMN_DEPTH)
  ) u_sampler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (fifo_op),
    .op_pop_o    (op_pop),
    .col_count_i (col_count),
    .col_push_o  (col_push),
    .col_o       (smp_col)
  );

  hmcv_fifo #(
    .WIDTH (ColW),
    .DEPTH (hmcv_pkg::COL_FIFO_DEPTH)
  ) u_col_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (col_push),
    .data_i  (smp_col),
    .full_o  (),
    .pop_i   (col_pop),
    .valid_o (col_valid),
    .data_o  (fifo_col_raw),
    .count_o (col_count)
  );

  assign fifo_col = hmcv_pkg::col_t'(fifo_col_raw);

  hmcv_emitter #(
    .COLUMN_DEPTH (COLUMN_DEPTH)
  ) u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .col_valid_i  (col_valid),
    .col_i        (fifo_col),
    .col_pop_o    (col_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_code_o   (out_code),
    .out_height_o (out_height),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_height, out_code};

endmodule

`default_nettype wire

>>> rtl/hmcv_fifo.sv
`default_nettype none

module hmcv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   slot_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;

  assign full_o  = (count_q == CntBits'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntBits'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hmcv_front.sv
`default_nettype none

module hmcv_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  hmcv_pkg::in_t                   in_i,
  input  logic [hmcv_pkg::SIDE_W-1:0]     map_side_i,
  input  logic [hmcv_pkg::RATIO_W-1:0]    step_ratio_i,
  output logic                            op_valid_o,
  input  logic                            op_ready_i,
  output hmcv_pkg::op_t                   op_o
);

  localparam int CW = hmcv_pkg::COORD_W;
  localparam int FW = hmcv_pkg::FRAC_W;
  localparam int PW = hmcv_pkg::PROD_W;
  localparam int RW = hmcv_pkg::ROW_W;

  logic          s1_valid_q, s2_valid_q, s3_valid_q;
  logic          ld1, ld2, ld3;
  hmcv_pkg::in_t s1_q, s2_q;
  logic [PW-1:0] px_q, pz_q;
  hmcv_pkg::op_t op_q, op_d;

  logic [CW-1:0] x1, z1, x2, z2;
  logic [CW:0]   x1_inc, z1_inc;

  assign ld3        = !s3_valid_q || op_ready_i;
  assign ld2        = !s2_valid_q || ld3;
  assign ld1        = !s1_valid_q || ld2;
  assign in_ready_o = ld1;
  assign op_valid_o = s3_valid_q;
  assign op_o       = op_q;

  always_comb begin
    x1     = px_q[PW-1:FW];
    z1     = pz_q[PW-1:FW];
    x1_inc = {1'b0, x1} + (CW+1)'(1);
    z1_inc = {1'b0, z1} + (CW+1)'(1);
    x2     = (x1_inc >= (CW+1)'(map_side_i)) ? x1 : x1_inc[CW-1:0];
    z2     = (z1_inc >= (CW+1)'(map_side_i)) ? z1 : z1_inc[CW-1:0];

    op_d       = op_q;
    op_d.func  = s2_q.func;
    op_d.idx   = s2_q.idx;
    op_d.value = s2_q.value;
    op_d.gx    = s2_q.gx;
    op_d.gz    = s2_q.gz;
    op_d.fx    = px_q[FW-1:0];
    op_d.fz    = pz_q[FW-1:0];
    op_d.x1    = x1;
    op_d.x2    = x2;
    op_d.r1    = RW'(z1) * RW'(map_side_i);
    op_d.r2    = RW'(z2) * RW'(map_side_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (ld1) s1_valid_q <= in_valid_i;
      if (ld2) s2_valid_q <= s1_valid_q;
      if (ld3) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) begin
      s1_q <= in_i;
    end
    if (ld2 && s1_valid_q) begin
      s2_q <= s1_q;
      px_q <= PW'(step_ratio_i) * PW'(s1_q.gx);
      pz_q <= PW'(step_ratio_i) * PW'(s1_q.gz);
    end
    if (ld3 && s2_valid_q) begin
      op_q <= op_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hmcv_sampler.sv
`default_nettype none

module hmcv_sampler #(
  parameter int MAP_BITS     = hmcv_pkg::MAP_BITS_DEF,
  parameter int TREE_BITS    = hmcv_pkg::TREE_BITS_DEF,
  parameter int COLUMN_DEPTH = hmcv_pkg::COLUMN_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              op_valid_i,
  input  hmcv_pkg::op_t                     op_i,
  output logic                              op_pop_o,
  input  logic [hmcv_pkg::COL_CNT_W-1:0]    col_count_i,
  output logic                              col_push_o,
  output hmcv_pkg::col_t                    col_o
);

  localparam int AddrBits = 2 * MAP_BITS;
  localparam int Depth    = 2 ** AddrBits;
  localparam int SumBits  = hmcv_pkg::ROW_W + 1;
  localparam int SW       = hmcv_pkg::SAMPLE_W;
  localparam int FW       = hmcv_pkg::FRAC_W;
  localparam int GW       = hmcv_pkg::GRID_W;
  localparam int HW       = hmcv_pkg::HEIGHT_W;
  localparam int CNT      = hmcv_pkg::COL_CNT_W;
  localparam int TopW     = 25;
  localparam int PTopW    = SW + FW + 2;
  localparam int PvW      = TopW + FW + 2;
  localparam int VW       = 41;
  localparam int HProdW   = VW + TREE_BITS;
  localparam logic [VW-1:0] VOne = VW'(1) << 40;
  localparam int IdxExtW = hmcv_pkg::IDX_W + AddrBits;

  function automatic logic [AddrBits-1:0] wrap_addr(input logic [hmcv_pkg::ROW_W-1:0] row,
                                                    input logic [hmcv_pkg::COORD_W-1:0] col);
    logic [SumBits-1:0]          sum;
    logic [SumBits+AddrBits-1:0] ext;
    sum = SumBits'(row) + SumBits'(col);
    ext = {{AddrBits{1'b0}}, sum};
    return ext[AddrBits-1:0];
  endfunction

  hmcv_pkg::smp_state_e state_q, state_d;

  logic [SW-1:0]       store [Depth];
  logic [SW-1:0]       rd0_q, rd1_q;
  logic [AddrBits-1:0] rd_addr0, rd_addr1, wr_addr;
  logic [IdxExtW-1:0]  idx_ext;
  logic                mem_we, start, credit_ok;
  logic [CNT-1:0]      inflight_q, inflight_d;

  logic [FW-1:0]                   m_fx_q, m_fz_q, b_fx_q, b_fz_q, p_fz_q, t_fz_q;
  logic [GW-1:0]                   m_gx_q, m_gz_q, b_gx_q, b_gz_q, p_gx_q, p_gz_q;
  logic [GW-1:0]                   t_gx_q, t_gz_q, v_gx_q, v_gz_q, c_gx_q, c_gz_q;
  logic [hmcv_pkg::COORD_W-1:0]    x1_q, x2_q;
  logic [hmcv_pkg::ROW_W-1:0]      r2_q;
  logic [SW-1:0]                   qa11_q, qa21_q, p_q11_q, p_q12_q;
  logic                            sa_q, sb_q, sp_q, st_q, sv_q, sc_q;

  logic signed [SW:0]              dtop, dbot;
  logic signed [PTopW-1:0]         ptop_q, pbot_q, sum_top, sum_bot;
  logic [TopW-1:0]                 top_q, bot_q, v_top_q;
  logic signed [TopW:0]            dv;
  logic signed [PvW-1:0]           pv_q, sum_v;
  logic [VW-1:0]                   v_raw, vc_q;
  logic [HProdW-1:0]               hprod;
  logic [TREE_BITS-1:0]            h;
  logic [TREE_BITS+HW-1:0]         h_ext;
  logic                            h_ok;

  assign idx_ext = {{AddrBits{1'b0}}, op_i.idx};
  assign wr_addr = idx_ext[AddrBits-1:0];
  assign credit_ok = ({1'b0, col_count_i} + {1'b0, inflight_q})
                     < (CNT+1)'(hmcv_pkg::COL_FIFO_DEPTH);

  always_comb begin
    state_d  = state_q;
    op_pop_o = 1'b0;
    mem_we   = 1'b0;
    start    = 1'b0;
    rd_addr0 = wrap_addr(op_i.r1, op_i.x1);
    rd_addr1 = wrap_addr(op_i.r1, op_i.x2);
    case (state_q)
      hmcv_pkg::SMP_IDLE: begin
        if (op_valid_i) begin
          if (op_i.func == hmcv_pkg::FUNC_WRITE) begin
            op_pop_o = 1'b1;
            mem_we   = 1'b1;
          end else if (credit_ok) begin
            op_pop_o = 1'b1;
            start    = 1'b1;
            state_d  = hmcv_pkg::SMP_ROWB;
          end
        end
      end
      hmcv_pkg::SMP_ROWB: begin
        rd_addr0 = wrap_addr(r2_q, x1_q);
        rd_addr1 = wrap_addr(r2_q, x2_q);
        state_d  = hmcv_pkg::SMP_IDLE;
      end
      default: state_d = hmcv_pkg::SMP_IDLE;
    endcase
  end

  always_comb begin
    inflight_d = inflight_q;
    if (start && !sc_q) begin
      inflight_d = inflight_q + CNT'(1);
    end else if (sc_q && !start) begin
      inflight_d = inflight_q - CNT'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hmcv_pkg::SMP_IDLE;
      inflight_q <= '0;
      sa_q       <= 1'b0;
      sb_q       <= 1'b0;
      sp_q       <= 1'b0;
      st_q       <= 1'b0;
      sv_q       <= 1'b0;
      sc_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      inflight_q <= inflight_d;
      sa_q       <= start;
      sb_q       <= sa_q;
      sp_q       <= sb_q;
      st_q       <= sp_q;
      sv_q       <= st_q;
      sc_q       <= sv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[wr_addr] <= op_i.value;
    end
    rd0_q <= store[rd_addr0];
    rd1_q <= store[rd_addr1];
  end

  always_comb begin
    dtop    = $signed({1'b0, qa21_q}) - $signed({1'b0, qa11_q});
    dbot    = $signed({1'b0, rd1_q}) - $signed({1'b0, rd0_q});
    sum_top = $signed({2'b00, p_q11_q, {FW{1'b0}}}) + ptop_q;
    sum_bot = $signed({2'b00, p_q12_q, {FW{1'b0}}}) + pbot_q;
    dv      = $signed({1'b0, bot_q}) - $signed({1'b0, top_q});
    sum_v   = $signed({2'b00, v_top_q, {FW{1'b0}}}) + pv_q;
    v_raw   = sum_v[VW+7:8];
    hprod   = {vc_q, {TREE_BITS{1'b0}}} - HProdW'(vc_q);
    h       = hprod[VW+TREE_BITS-2:VW-1];
    h_ok    = (TREE_BITS+7)'(h) >= (TREE_BITS+7)'(COLUMN_DEPTH);
    h_ext   = {{HW{1'b0}}, h};
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      m_fx_q <= op_i.fx;
      m_fz_q <= op_i.fz;
      m_gx_q <= op_i.gx;
      m_gz_q <= op_i.gz;
      x1_q   <= op_i.x1;
      x2_q   <= op_i.x2;
      r2_q   <= op_i.r2;
    end
    qa11_q  <= rd0_q;
    qa21_q  <= rd1_q;
    b_fx_q  <= m_fx_q;
    b_fz_q  <= m_fz_q;
    b_gx_q  <= m_gx_q;
    b_gz_q  <= m_gz_q;
    ptop_q  <= dtop * $signed({1'b0, b_fx_q});
    pbot_q  <= dbot * $signed({1'b0, b_fx_q});
    p_q11_q <= qa11_q;
    p_q12_q <= rd0_q;
    p_fz_q  <= b_fz_q;
    p_gx_q  <= b_gx_q;
    p_gz_q  <= b_gz_q;
    top_q   <= sum_top[TopW+15:16];
    bot_q   <= sum_bot[TopW+15:16];
    t_fz_q  <= p_fz_q;
    t_gx_q  <= p_gx_q;
    t_gz_q  <= p_gz_q;
    pv_q    <= dv * $signed({1'b0, t_fz_q});
    v_top_q <= top_q;
    v_gx_q  <= t_gx_q;
    v_gz_q  <= t_gz_q;
    vc_q    <= (v_raw > VOne) ? VOne : v_raw;
    c_gx_q  <= v_gx_q;
    c_gz_q  <= v_gz_q;
  end

  assign col_push_o = sc_q && h_ok;
  assign col_o.gx   = c_gx_q;
  assign col_o.gz   = c_gz_q;
  assign col_o.hlo  = h_ext[HW-1:0];

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_push_o |-> (col_count_i < CNT'(hmcv_pkg::COL_FIFO_DEPTH)))
    else $error("column pushed into a full queue");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_count_i} + {1'b0, inflight_q}) <= (CNT+1)'(hmcv_pkg::COL_FIFO_DEPTH))
    else $error("columns in flight exceed queue space");

  a_no_pop_second_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hmcv_pkg::SMP_ROWB) |-> !op_pop_o)
    else $error("operation taken during second row read");

  a_start_then_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == hmcv_pkg::SMP_ROWB) && sa_q)
    else $error("second row read missing after column start");

endmodule

`default_nettype wire

>>> rtl/hmcv_emitter.sv
`default_nettype none

module hmcv_emitter #(
  parameter int COLUMN_DEPTH = hmcv_pkg::COLUMN_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             col_valid_i,
  input  hmcv_pkg::col_t                   col_i,
  output logic                             col_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hmcv_pkg::MORTON_W-1:0]    out_code_o,
  output logic [hmcv_pkg::HEIGHT_W-1:0]    out_height_o,
  output logic                             out_last_o
);

  localparam int KBits = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;
  localparam int GW    = hmcv_pkg::GRID_W;
  localparam int HW    = hmcv_pkg::HEIGHT_W;

  logic                         cur_q, ov_q, last_q;
  logic [KBits-1:0]             k_q;
  logic [GW-1:0]                y_q, gx_q, gz_q;
  logic [HW-1:0]                h_q, height_q;
  logic [hmcv_pkg::MORTON_W-1:0] code_q;
  logic                         is_last, advance;

  assign is_last      = (k_q == KBits'(COLUMN_DEPTH - 1));
  assign advance      = cur_q && (!ov_q || out_ready_i);
  assign col_pop_o    = col_valid_i && (!cur_q || (advance && is_last));
  assign out_valid_o  = ov_q;
  assign out_code_o   = code_q;
  assign out_height_o = height_q;
  assign out_last_o   = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 1'b0;
      ov_q  <= 1'b0;
      k_q   <= '0;
    end else begin
      if (col_pop_o) begin
        cur_q <= 1'b1;
      end else if (advance && is_last) begin
        cur_q <= 1'b0;
      end
      if (advance) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (col_pop_o) begin
        k_q <= '0;
      end else if (advance) begin
        k_q <= k_q + KBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_pop_o) begin
      y_q  <= col_i.hlo - HW'(COLUMN_DEPTH);
      gx_q <= col_i.gx;
      gz_q <= col_i.gz;
      h_q  <= col_i.hlo;
    end else if (advance) begin
      y_q <= y_q + GW'(1);
    end
    if (advance) begin
      code_q   <= hmcv_pkg::interleave3(gx_q, y_q, gz_q);
      height_q <= h_q;
      last_q   <= is_last;
    end
  end

endmodule

`default_nettype wire

>>> test/voxel_stream_checker.sv
module voxel_stream_checker
  import hmcv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [RATIO_W-1:0]   cfg_data_i,
  output int                   fail_cnt_o,
  output int                   pending_o,
  output int                   voxels_o
);

  localparam int STORE_DEPTH = 1 << (2 * MAP_BITS_DEF);
  localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_W;
  localparam longint unsigned UNIT_Q40 = 64'd1 << 40;
  localparam longint unsigned HEIGHT_SCALE = (64'd1 << TREE_BITS_DEF) - 1;

  typedef struct packed {
    logic [MORTON_W-1:0] code;
    logic [HEIGHT_W-1:0] height;
    logic                last;
  } voxel_t;

  voxel_t              expected_voxels[$];
  logic [SAMPLE_W-1:0] heights [STORE_DEPTH];
  logic [SIDE_W-1:0]   side;
  logic [RATIO_W-1:0]  ratio;

  task automatic report(input string what);
    if (fail_cnt_o < 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fail_cnt_o++;
  endtask

  function automatic logic [MORTON_W-1:0] spread_xyz(input logic [GRID_W-1:0] x,
                                                     input logic [GRID_W-1:0] y,
                                                     input logic [GRID_W-1:0] z);
    logic [MORTON_W-1:0] acc;
    acc = '0;
    for (int b = GRID_W - 1; b >= 0; b--) begin
      acc = {acc[MORTON_W-4:0], z[b], y[b], x[b]};
    end
    return acc;
  endfunction

  function automatic longint unsigned corner(input longint unsigned row,
                                             input longint unsigned col);
    longint unsigned addr;
    addr = row * side + col;
    return heights[addr % STORE_DEPTH];
  endfunction

  task automatic predict_column(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gz);
    longint unsigned px, pz, x1, z1, x2, z2, fx, fz;
    longint unsigned q11, q12, q21, q22, top, bot, v, h;
    voxel_t vox;
    px = 64'(ratio) * 64'(gx);
    pz = 64'(ratio) * 64'(gz);
    x1 = px >> FRAC_W;
    z1 = pz >> FRAC_W;
    fx = px & (FRAC_ONE - 1);
    fz = pz & (FRAC_ONE - 1);
    x2 = (x1 + 1 >= side) ? x1 : x1 + 1;
    z2 = (z1 + 1 >= side) ? z1 : z1 + 1;
    q11 = corner(z1, x1);
    q21 = corner(z1, x2);
    q12 = corner(z2, x1);
    q22 = corner(z2, x2);
    top = (q11 * (FRAC_ONE - fx) + q21 * fx) >> 16;
    bot = (q12 * (FRAC_ONE - fx) + q22 * fx) >> 16;
    v = (top * (FRAC_ONE - fz) + bot * fz) >> 8;
    if (v > UNIT_Q40) begin
      v = UNIT_Q40;
    end
    h = (v * HEIGHT_SCALE) >> 40;
    if (h >= COLUMN_DEPTH_DEF) begin
      for (int k = 0; k < COLUMN_DEPTH_DEF; k++) begin
        vox.code   = spread_xyz(gx, GRID_W'(h - COLUMN_DEPTH_DEF + k), gz);
        vox.height = HEIGHT_W'(h);
        vox.last   = (k == COLUMN_DEPTH_DEF - 1);
        expected_voxels = {expected_voxels, vox};
      end
    end
  endtask

  always @(posedge clk_i) begin
    voxel_t want;
    if (!rst_ni) begin
      side  = MAP_SIDE_RST;
      ratio = STEP_RATIO_RST;
      expected_voxels.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CFG_MAP_SIDE) begin
          side = cfg_data_i[SIDE_W-1:0];
        end else begin
          ratio = cfg_data_i;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (func_e'(s_axis_tuser) == FUNC_WRITE) begin
          heights[s_axis_tdata[IDX_W-1:0]] = s_axis_tdata[IDX_W +: SAMPLE_W];
        end else begin
          predict_column(s_axis_tdata[IDX_W+SAMPLE_W +: GRID_W],
                         s_axis_tdata[IDX_W+SAMPLE_W+GRID_W +: GRID_W]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        voxels_o++;
        if (expected_voxels.size() == 0) begin
          report($sformatf("unexpected voxel beat, code %h", m_axis_tdata[MORTON_W-1:0]));
        end else begin
          want = expected_voxels.pop_front();
          if (m_axis_tdata[MORTON_W-1:0] !== want.code) begin
            report($sformatf("morton code %h, expected %h",
                             m_axis_tdata[MORTON_W-1:0], want.code));
          end
          if (m_axis_tdata[MORTON_W +: HEIGHT_W] !== want.height) begin
            report($sformatf("column height %0d, expected %0d",
                             m_axis_tdata[MORTON_W +: HEIGHT_W], want.height));
          end
          if (m_axis_tlast !== want.last) begin
            report($sformatf("tlast %b, expected %b", m_axis_tlast, want.last));
          end
        end
      end
    end
    pending_o = expected_voxels.size();
  end

endmodule

>>> test/tb.sv
module tb;
  import hmcv_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int STORE_DEPTH   = 1 << (2 * MAP_BITS_DEF);
  localparam int UNIT_SAMPLE   = 65536;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  localparam int RATIO_ONE     = 1 << FRAC_W;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i;
  logic                 cfg_idx_i;
  logic [RATIO_W-1:0]   cfg_data_i;

  int                   fail_cnt;
  int                   pending;
  int                   voxels;
  int                   cycles;
  int                   beats;
  int                   columns;
  int                   settings;
  bit                   steady;
  bit                   written [STORE_DEPTH];
  logic [SIDE_W-1:0]    side_now;
  logic [RATIO_W-1:0]   ratio_now;

  heightmap_column_voxelizer_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  voxel_stream_checker voxel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .voxels_o     (voxels)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing.", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int run;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      if (!steady) begin
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        m_axis_tready = 1'b0;
        run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (run - 1) @(negedge clk_i);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic send_beat(input func_e f, input logic [IDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] value,
                           input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gz);
    int gap;
    gap = sender_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = f;
    s_axis_tdata  = {3'b000, gz, gx, value, idx};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    beats++;
  endtask

  task automatic write_sample(input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
    send_beat(FUNC_WRITE, idx, value, GRID_W'($urandom), GRID_W'($urandom));
    written[idx] = 1'b1;
  endtask

  // Store addresses of the four interpolation neighbors under the current settings.
  function automatic logic [4*IDX_W-1:0] corner_addrs(input logic [GRID_W-1:0] gx,
                                                      input logic [GRID_W-1:0] gz);
    longint unsigned x1, z1, x2, z2;
    x1 = (64'(ratio_now) * 64'(gx)) >> FRAC_W;
    z1 = (64'(ratio_now) * 64'(gz)) >> FRAC_W;
    x2 = (x1 + 1 >= side_now) ? x1 : x1 + 1;
    z2 = (z1 + 1 >= side_now) ? z1 : z1 + 1;
    return {IDX_W'(z2 * side_now + x2), IDX_W'(z2 * side_now + x1),
            IDX_W'(z1 * side_now + x2), IDX_W'(z1 * side_now + x1)};
  endfunction

  task automatic gen_column(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gz,
                            input bit refill, input int lo, input int hi);
    logic [4*IDX_W-1:0] addrs;
    logic [IDX_W-1:0]   a;
    addrs = corner_addrs(gx, gz);
    for (int i = 0; i < 4; i++) begin
      a = addrs[i*IDX_W +: IDX_W];
      if (refill || !written[a] || $urandom_range(0, 3) == 0) begin
        write_sample(a, SAMPLE_W'($urandom_range(lo, hi)));
      end
    end
    send_beat(FUNC_GEN, IDX_W'($urandom), SAMPLE_W'($urandom), gx, gz);
    columns++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [RATIO_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_MAP_SIDE) begin
      side_now = value[SIDE_W-1:0];
    end else begin
      ratio_now = value;
    end
  endtask

  task automatic apply_setting(input logic [SIDE_W-1:0] side, input logic [RATIO_W-1:0] ratio);
    drain();
    write_register(CFG_MAP_SIDE, RATIO_W'(side));
    write_register(CFG_STEP_RATIO, ratio);
    settings++;
  endtask

  task automatic run_random(input int ops);
    int r, lo, hi;
    repeat (ops) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        write_sample(IDX_W'($urandom), SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          lo = 0;
          hi = UNIT_SAMPLE;
        end else if (r < 70) begin
          lo = UNIT_SAMPLE + 1;
          hi = SAMPLE_MAX;
        end else if (r < 88) begin
          lo = 0;
          hi = 1200;
        end else begin
          lo = 60000;
          hi = UNIT_SAMPLE;
        end
        gen_column(GRID_W'($urandom), GRID_W'($urandom), 1'b0, lo, hi);
      end
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = 1'b0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    side_now      = MAP_SIDE_RST;
    ratio_now     = STEP_RATIO_RST;
    repeat (2) @(negedge clk_i);
    rst_ni   = 1'b1;
    settings = 1;

    // Full-scale, clamped, just-too-short and just-tall-enough columns.
    write_sample(16'hFFFF, SAMPLE_W'(UNIT_SAMPLE));
    gen_column(10'd0, 10'd0, 1'b1, UNIT_SAMPLE, UNIT_SAMPLE);
    gen_column(10'd1023, 10'd1023, 1'b1, SAMPLE_MAX, SAMPLE_MAX);
    gen_column(10'd512, 10'd3, 1'b1, 640, 640);
    gen_column(10'd3, 10'd512, 1'b1, 641, 641);
    run_random(5);

    apply_setting(9'd2, RATIO_W'(RATIO_ONE));
    run_random(5);
    steady = 1'b1;
    apply_setting(9'd256, '0);
    run_random(5);
    steady = 1'b0;
    apply_setting(SIDE_W'($urandom_range(2, 256)), RATIO_W'($urandom_range(0, RATIO_ONE)));
    run_random(5);
    apply_setting(9'd256, RATIO_W'(RATIO_ONE));
    run_random(5);
    apply_setting(SIDE_W'($urandom_range(2, 40)), RATIO_W'($urandom_range(0, RATIO_ONE)));
    run_random(5);
    drain();

    $display("Drove %0d input beats, %0d of them columns, across %0d register settings.",
             beats, columns, settings);
    $display("Compared %0d output beats with the predicted voxel codes.", voxels);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
